// ===== hw/rtl/uart_sp_pkg.sv =====
// Shared types and constants for the serial port transmitter and receiver.
package uart_sp_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned WLEN_W     = 4;
  localparam int unsigned BIT_IDX_W  = 4;
  localparam int unsigned RX_CNT_W   = PERIOD_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = PERIOD_W;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH = 1'b1;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd3285;
  localparam logic [WLEN_W-1:0]   WORD_LEN_RST   = 4'd8;
  localparam logic [WLEN_W-1:0]   MAX_WORD       = 4'd8;

  typedef struct packed {
    logic [PERIOD_W-1:0] bit_period;
    logic [WLEN_W-1:0]   word_len;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } rx_res_t;

  typedef struct packed {
    logic line_out;
    logic taken;
    logic start;
  } tx_res_t;

endpackage

// ===== hw/rtl/uart_sp_if.sv =====
// Handshake interfaces for the tick input channel and the result channel.
interface uart_sp_in_if;
  import uart_sp_pkg::*;

  logic              valid;
  logic              ready;
  logic              line_in;
  logic              send_valid;
  logic [DATA_W-1:0] send_byte;

  modport source (output valid, output line_in, output send_valid, output send_byte,
                  input ready);
  modport sink (input valid, input line_in, input send_valid, input send_byte,
                output ready);
endinterface

interface uart_sp_out_if;
  import uart_sp_pkg::*;

  logic              valid;
  logic              ready;
  logic              line_out;
  logic              recv_valid;
  logic [DATA_W-1:0] recv_byte;
  logic              send_taken;
  logic              start_flag;

  modport source (output valid, output line_out, output recv_valid, output recv_byte,
                  output send_taken, output start_flag, input ready);
  modport sink (input valid, input line_out, input recv_valid, input recv_byte,
                input send_taken, input start_flag, output ready);
endinterface

// ===== hw/rtl/uart_sp_rx.sv =====
// Serial receiver state and its per-tick next-state and result logic.
module uart_sp_rx (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          line_in,
  input  uart_sp_pkg::cfg_t             cfg,
  output uart_sp_pkg::rx_res_t          res
);
  import uart_sp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [RX_CNT_W-1:0]  cnt_r, cnt_nxt, cnt_dec;
  logic [BIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0]    shift_r, shift_nxt;

  assign cnt_dec = (cnt_r != '0) ? cnt_r - RX_CNT_W'(1) : cnt_r;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    res       = '0;
    if (!busy_r) begin
      if (!line_in) begin
        busy_nxt  = 1'b1;
        idx_nxt   = '0;
        shift_nxt = '0;
        cnt_nxt   = {1'b0, cfg.bit_period} + {2'b00, cfg.bit_period[PERIOD_W-1:1]};
      end
    end else begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        if (idx_r < cfg.word_len) begin
          if (line_in) begin
            shift_nxt[idx_r[2:0]] = 1'b1;
          end
          idx_nxt = idx_r + BIT_IDX_W'(1);
          cnt_nxt = {1'b0, cfg.bit_period};
        end else begin
          res.valid = 1'b1;
          res.data  = shift_r;
          busy_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      idx_r   <= '0;
      shift_r <= '0;
    end else if (step) begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// ===== hw/rtl/uart_sp_tx.sv =====
// Serial transmitter state and its per-tick next-state and result logic.
module uart_sp_tx (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          send_valid,
  input  logic [uart_sp_pkg::DATA_W-1:0] send_byte,
  input  uart_sp_pkg::cfg_t             cfg,
  output uart_sp_pkg::tx_res_t          res
);
  import uart_sp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [PERIOD_W-1:0]  cnt_r, cnt_nxt, cnt_dec;
  logic [BIT_IDX_W-1:0] idx_r, idx_nxt, idx_inc;
  logic [DATA_W-1:0]    shift_r, shift_nxt;
  logic                 lvl_r, lvl_nxt;

  assign cnt_dec = (cnt_r != '0) ? cnt_r - PERIOD_W'(1) : cnt_r;
  assign idx_inc = idx_r + BIT_IDX_W'(1);

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    lvl_nxt   = lvl_r;
    res       = '0;
    if (!busy_r) begin
      if (send_valid) begin
        busy_nxt  = 1'b1;
        shift_nxt = send_byte;
        idx_nxt   = '0;
        lvl_nxt   = 1'b0;
        cnt_nxt   = cfg.bit_period;
        res.taken = 1'b1;
        res.start = 1'b1;
      end else begin
        lvl_nxt = 1'b1;
      end
    end else begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == '0) begin
        idx_nxt = idx_inc;
        if (idx_inc <= cfg.word_len) begin
          lvl_nxt = shift_r[idx_r[2:0]];
          cnt_nxt = cfg.bit_period;
        end else if (idx_inc == cfg.word_len + BIT_IDX_W'(1)) begin
          lvl_nxt = 1'b1;
          cnt_nxt = cfg.bit_period;
        end else begin
          busy_nxt = 1'b0;
          lvl_nxt  = 1'b1;
        end
      end
    end
    res.line_out = lvl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      idx_r   <= '0;
      shift_r <= '0;
      lvl_r   <= 1'b1;
    end else if (step) begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

endmodule

// ===== hw/rtl/uart_rx_tx_serial_port.sv =====
// Top level of the serial port: input stage, receiver, transmitter and result register.
//
//   Channel  Dir  Contents
//   in_ch    in   line_in, send_valid, send_byte (one clock tick of serial timing)
//   out_ch   out  line_out, recv_valid, recv_byte, send_taken, start_flag
//   cfg_*    in   register writes: bit_period (index 0), word_length (index 1)
//
// One transaction is accepted per cycle unless out_ch stalls; it passes both stages.
// Each accepted transaction advances the receiver and transmitter by one serial tick.
// Reset clears both pipeline stages and loads the register reset values.
// When the result is not taken, the stages hold and no serial state advances.
module uart_rx_tx_serial_port (
  input  logic                              clk,
  input  logic                              rst_n,
  uart_sp_in_if.sink                        in_ch,
  uart_sp_out_if.source                     out_ch,
  input  logic                              cfg_we,
  input  logic [uart_sp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uart_sp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import uart_sp_pkg::*;

  logic [PERIOD_W-1:0] bit_period_r;
  logic [WLEN_W-1:0]   word_len_r;
  cfg_t                cfg;

  logic              stg_valid_r;
  logic              stg_line_r;
  logic              stg_send_valid_r;
  logic [DATA_W-1:0] stg_send_byte_r;

  logic              out_valid_r;
  logic              out_line_r;
  logic              out_recv_valid_r;
  logic [DATA_W-1:0] out_recv_byte_r;
  logic              out_taken_r;
  logic              out_start_r;

  logic    advance;
  rx_res_t rx_res;
  tx_res_t tx_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RST;
      word_len_r   <= WORD_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_PERIOD:  bit_period_r <= cfg_wdata;
        REG_WORD_LENGTH: word_len_r   <= cfg_wdata[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = {bit_period_r, ((word_len_r > MAX_WORD) ? MAX_WORD : word_len_r)};

  assign advance     = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_line_r       <= in_ch.line_in;
      stg_send_valid_r <= in_ch.send_valid;
      stg_send_byte_r  <= in_ch.send_byte;
    end
  end

  uart_sp_rx u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .line_in (stg_line_r),
    .cfg     (cfg),
    .res     (rx_res)
  );

  uart_sp_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .send_valid (stg_send_valid_r),
    .send_byte  (stg_send_byte_r),
    .cfg        (cfg),
    .res        (tx_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_line_r       <= tx_res.line_out;
      out_recv_valid_r <= rx_res.valid;
      out_recv_byte_r  <= rx_res.data;
      out_taken_r      <= tx_res.taken;
      out_start_r      <= tx_res.start;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.line_out   = out_line_r;
  assign out_ch.recv_valid = out_recv_valid_r;
  assign out_ch.recv_byte  = out_recv_byte_r;
  assign out_ch.send_taken = out_taken_r;
  assign out_ch.start_flag = out_start_r;

`ifndef SYNTHESIS
  a_byte_zero_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.recv_valid) |-> (out_ch.recv_byte == '0))
    else $error("Received byte is nonzero without a completed frame.");

  a_start_with_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.start_flag == out_ch.send_taken))
    else $error("Start flag and send taken disagree.");

  a_start_drives_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.start_flag) |-> !out_ch.line_out)
    else $error("Line is not low at the start of a frame.");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("Input accepted while both stages are blocked.");
`endif

endmodule
